/* sv/ccx_pkg.sv */
// Shared constants, types and helper functions of the ChaCha20 stream XOR unit.
package ccx_pkg;

   localparam int CCX_ROUND_COUNT = 20;

   localparam int CCX_WORD_W  = 32;
   localparam int CCX_ROW_W   = 4 * CCX_WORD_W;
   localparam int CCX_STATE_W = 4 * CCX_ROW_W;
   localparam int CCX_KEY_W   = 256;
   localparam int CCX_NONCE_W = 96;

   localparam int CCX_CSR_INDEX_W = 3;
   localparam int CCX_CSR_DATA_W  = 64;

   localparam logic [CCX_CSR_INDEX_W-1:0] CSR_KEY_0_7     = 3'd0;
   localparam logic [CCX_CSR_INDEX_W-1:0] CSR_KEY_8_15    = 3'd1;
   localparam logic [CCX_CSR_INDEX_W-1:0] CSR_KEY_16_23   = 3'd2;
   localparam logic [CCX_CSR_INDEX_W-1:0] CSR_KEY_24_31   = 3'd3;
   localparam logic [CCX_CSR_INDEX_W-1:0] CSR_NONCE_0_7   = 3'd4;
   localparam logic [CCX_CSR_INDEX_W-1:0] CSR_NONCE_8_11  = 3'd5;
   localparam logic [CCX_CSR_INDEX_W-1:0] CSR_INIT_CTR    = 3'd6;

   // The four constant words, word 0 in the low bits.
   localparam logic [CCX_ROW_W-1:0] CCX_SIGMA =
      {32'h6b206574, 32'h79622d32, 32'h3320646e, 32'h61707865};

   // Rotate amounts of the four quarter-round steps.
   localparam int unsigned CCX_ROT [4] = '{16, 12, 8, 7};

   typedef struct packed {
      logic start;
      logic shift;
   } ccx_ctl_type;

   typedef struct packed {
      logic [CCX_KEY_W-1:0]   key;
      logic [CCX_NONCE_W-1:0] nonce;
   } ccx_cfg_type;

   function automatic logic [CCX_WORD_W-1:0] rotl32(input logic [CCX_WORD_W-1:0] v,
                                                    input int unsigned n);
      return (v << n) | (v >> (CCX_WORD_W - n));
   endfunction

   // Lane i of the result takes lane (i + k) mod 4 of the row.
   function automatic logic [CCX_ROW_W-1:0] word_rot(input logic [CCX_ROW_W-1:0] row,
                                                     input int unsigned k);
      logic [CCX_ROW_W-1:0] r;
      r = '0;
      for (int i = 0; i < 4; i++) begin
         r[CCX_WORD_W*i +: CCX_WORD_W] = row[CCX_WORD_W*((i + k) % 4) +: CCX_WORD_W];
      end
      return r;
   endfunction

endpackage

/* sv/ccx_lane_alu.sv */
// Four-lane quarter-round step unit: add, then xor and rotate.
module ccx_lane_alu import ccx_pkg::*; (
   input  logic [CCX_ROW_W-1:0] x,
   input  logic [CCX_ROW_W-1:0] y,
   input  logic [CCX_ROW_W-1:0] z,
   input  logic [1:0]           rot_sel,
   output logic [CCX_ROW_W-1:0] sum,
   output logic [CCX_ROW_W-1:0] mix
);

   always_comb begin
      logic [CCX_WORD_W-1:0] s;
      for (int i = 0; i < 4; i++) begin
         s = x[CCX_WORD_W*i +: CCX_WORD_W] + y[CCX_WORD_W*i +: CCX_WORD_W];
         sum[CCX_WORD_W*i +: CCX_WORD_W] = s;
         mix[CCX_WORD_W*i +: CCX_WORD_W] =
            rotl32(z[CCX_WORD_W*i +: CCX_WORD_W] ^ s, CCX_ROT[rot_sel]);
      end
   end

endmodule

/* sv/ccx_core.sv */
// Block generator: state registers, round sequencer and keystream shift-out.
module ccx_core import ccx_pkg::*; #(
   parameter int ROUND_COUNT = CCX_ROUND_COUNT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  ccx_ctl_type           ctl,
   input  ccx_cfg_type           cfg,
   input  logic [CCX_WORD_W-1:0] block_ctr,
   output logic                  busy,
   output logic [7:0]            ks_byte
);

   localparam int HALF_ROUNDS = 2 * ((ROUND_COUNT + 1) / 2);
   localparam int HALF_W      = $clog2(HALF_ROUNDS);
   localparam logic [HALF_W-1:0] HALF_LAST = HALF_W'(HALF_ROUNDS - 1);

   localparam logic [1:0] C_IDLE  = 2'd0;
   localparam logic [1:0] C_ROUND = 2'd1;
   localparam logic [1:0] C_FINAL = 2'd2;
   localparam logic [1:0] STEP_LAST = 2'd3;

   logic [1:0]             seq_ff, seq_in;
   logic [1:0]             step_ff, step_in;
   logic [HALF_W-1:0]      half_ff, half_in;
   logic [CCX_STATE_W-1:0] st_ff, st_in;
   logic [CCX_WORD_W-1:0]  ctr_ff, ctr_in;

   logic [CCX_ROW_W-1:0] row_a, row_b, row_c, row_d;
   logic [CCX_ROW_W-1:0] fin_row;
   logic [CCX_ROW_W-1:0] alu_x, alu_y, alu_z, alu_sum, alu_mix;
   logic [CCX_ROW_W-1:0] nb, nc;

   assign row_a = st_ff[0*CCX_ROW_W +: CCX_ROW_W];
   assign row_b = st_ff[1*CCX_ROW_W +: CCX_ROW_W];
   assign row_c = st_ff[2*CCX_ROW_W +: CCX_ROW_W];
   assign row_d = st_ff[3*CCX_ROW_W +: CCX_ROW_W];

   assign busy    = (seq_ff != C_IDLE);
   assign ks_byte = st_ff[7:0];

   always_comb begin
      case (step_ff)
         2'd0:    fin_row = CCX_SIGMA;
         2'd1:    fin_row = cfg.key[CCX_ROW_W-1:0];
         2'd2:    fin_row = cfg.key[CCX_KEY_W-1:CCX_ROW_W];
         default: fin_row = {cfg.nonce, ctr_ff};
      endcase
   end

   always_comb begin
      case (seq_ff)
         C_FINAL: begin
            alu_x = row_a;
            alu_y = fin_row;
            alu_z = row_d;
         end
         default: begin
            if (!step_ff[0]) begin
               alu_x = row_a;
               alu_y = row_b;
               alu_z = row_d;
            end else begin
               alu_x = row_c;
               alu_y = row_d;
               alu_z = row_b;
            end
         end
      endcase
   end

   ccx_lane_alu u_alu (
      .x       (alu_x),
      .y       (alu_y),
      .z       (alu_z),
      .rot_sel (step_ff),
      .sum     (alu_sum),
      .mix     (alu_mix)
   );

   always_comb begin
      seq_in  = seq_ff;
      step_in = step_ff;
      half_in = half_ff;
      st_in   = st_ff;
      ctr_in  = ctr_ff;
      nb      = alu_mix;
      nc      = alu_sum;
      case (seq_ff)
         C_IDLE: begin
            if (ctl.start) begin
               st_in   = {cfg.nonce, block_ctr, cfg.key, CCX_SIGMA};
               ctr_in  = block_ctr;
               step_in = '0;
               half_in = '0;
               seq_in  = C_ROUND;
            end else if (ctl.shift) begin
               st_in = st_ff >> 8;
            end
         end
         C_ROUND: begin
            step_in = step_ff + 2'd1;
            if (!step_ff[0]) begin
               st_in = {alu_mix, row_c, row_b, alu_sum};
            end else begin
               if (step_ff == STEP_LAST) begin
                  if (!half_ff[0]) begin
                     nb    = word_rot(alu_mix, 1);
                     nc    = word_rot(alu_sum, 2);
                     st_in = {word_rot(row_d, 3), nc, nb, row_a};
                  end else begin
                     nb    = word_rot(alu_mix, 3);
                     nc    = word_rot(alu_sum, 2);
                     st_in = {word_rot(row_d, 1), nc, nb, row_a};
                  end
                  if (half_ff == HALF_LAST) begin
                     seq_in = C_FINAL;
                  end else begin
                     half_in = half_ff + 1'b1;
                  end
               end else begin
                  st_in = {row_d, nc, nb, row_a};
               end
            end
         end
         C_FINAL: begin
            step_in = step_ff + 2'd1;
            st_in   = {alu_sum, row_d, row_c, row_b};
            if (step_ff == STEP_LAST) begin
               seq_in = C_IDLE;
            end
         end
         default: begin
            seq_in = C_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seq_ff  <= C_IDLE;
         step_ff <= '0;
         half_ff <= '0;
      end else begin
         seq_ff  <= seq_in;
         step_ff <= step_in;
         half_ff <= half_in;
      end
      st_ff  <= st_in;
      ctr_ff <= ctr_in;
   end

   a_start_idle : assert property (@(posedge clock) disable iff (reset)
      ctl.start |-> (seq_ff == C_IDLE))
      else $error("Block start while a block is being generated.");

   a_shift_idle : assert property (@(posedge clock) disable iff (reset)
      ctl.shift |-> (seq_ff == C_IDLE && !ctl.start))
      else $error("Keystream shift while the state is in use.");

   a_start_seq : assert property (@(posedge clock) disable iff (reset)
      ctl.start |=> (seq_ff == C_ROUND && step_ff == 2'd0 && half_ff == '0))
      else $error("Round sequence did not begin at the first step.");

   a_final_entry : assert property (@(posedge clock) disable iff (reset)
      (seq_ff == C_FINAL && step_ff == 2'd0) |->
         ($past(seq_ff) == C_ROUND && $past(half_ff) == HALF_LAST))
      else $error("Feed-forward entered before the last round.");

endmodule

/* sv/chacha20_stream_xor_unit.sv */
// Top level of the ChaCha20 stream XOR unit: configuration, stream handshake, byte sequencing.
// A byte from a filled keystream block is accepted and its result registered as it is accepted.
// The first byte of each 64-byte block waits for the block generator to run all rounds and
// then the feed-forward, and no further byte is accepted until that byte's result is registered.
// Synchronous active-high reset clears the configuration, the block count and marks the
// keystream buffer empty; no clearing pass is needed.
module chacha20_stream_xor_unit import ccx_pkg::*; #(
   parameter int ROUND_COUNT = CCX_ROUND_COUNT
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_tvalid,
   output logic                       req_tready,
   input  logic [7:0]                 req_tdata,   // [7:0] data_byte
   input  logic                       req_tlast,   // last_byte
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   output logic [7:0]                 rsp_tdata,   // [7:0] out_byte
   output logic                       rsp_tlast,   // out_last
   input  logic                       csr_we,
   input  logic [CCX_CSR_INDEX_W-1:0] csr_index,
   input  logic [CCX_CSR_DATA_W-1:0]  csr_wdata
);

   localparam logic T_IDLE = 1'b0;
   localparam logic T_GEN  = 1'b1;
   localparam logic [6:0] POS_EMPTY = 7'd64;

   logic [63:0] key0_ff, key1_ff, key2_ff, key3_ff, non0_ff;
   logic [31:0] non1_ff, ictr_ff;

   logic                  st_ff, st_in;
   logic [6:0]            pos_ff, pos_in;
   logic [CCX_WORD_W-1:0] blk_ff, blk_in;
   logic [7:0]            hold_data_ff;
   logic                  hold_last_ff;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [7:0]            rsp_data_ff;
   logic                  rsp_last_ff;

   logic        out_free, accept, gen_start, emit_now, emit_gen, emit;
   logic [7:0]  emit_data;
   logic        emit_last;
   logic        core_busy;
   logic [7:0]  ks_byte;
   ccx_ctl_type ctl;
   ccx_cfg_type cfg;

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign req_tready = (st_ff == T_IDLE) && out_free;
   assign accept     = req_tvalid && req_tready;
   assign gen_start  = accept && pos_ff[6];
   assign emit_now   = accept && !pos_ff[6];
   assign emit_gen   = (st_ff == T_GEN) && !core_busy && out_free;
   assign emit       = emit_now || emit_gen;
   assign emit_data  = (st_ff == T_GEN) ? hold_data_ff : req_tdata;
   assign emit_last  = (st_ff == T_GEN) ? hold_last_ff : req_tlast;

   assign ctl.start = gen_start;
   assign ctl.shift = emit;
   assign cfg.key   = {key3_ff, key2_ff, key1_ff, key0_ff};
   assign cfg.nonce = {non1_ff, non0_ff};

   ccx_core #(
      .ROUND_COUNT (ROUND_COUNT)
   ) u_core (
      .clock     (clock),
      .reset     (reset),
      .ctl       (ctl),
      .cfg       (cfg),
      .block_ctr (ictr_ff + blk_ff),
      .busy      (core_busy),
      .ks_byte   (ks_byte)
   );

   always_comb begin
      st_in        = st_ff;
      pos_in       = pos_ff;
      blk_in       = blk_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      if (gen_start) begin
         st_in = T_GEN;
      end
      if (emit_gen) begin
         st_in  = T_IDLE;
         pos_in = 7'd1;
         blk_in = blk_ff + 1'b1;
      end
      if (emit_now) begin
         pos_in = pos_ff + 7'd1;
      end
      if (emit) begin
         rsp_valid_in = 1'b1;
         if (emit_last) begin
            pos_in = POS_EMPTY;
            blk_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff        <= T_IDLE;
         pos_ff       <= POS_EMPTY;
         blk_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         st_ff        <= st_in;
         pos_ff       <= pos_in;
         blk_ff       <= blk_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      if (gen_start) begin
         hold_data_ff <= req_tdata;
         hold_last_ff <= req_tlast;
      end
      if (emit) begin
         rsp_data_ff <= emit_data ^ ks_byte;
         rsp_last_ff <= emit_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key0_ff <= '0;
         key1_ff <= '0;
         key2_ff <= '0;
         key3_ff <= '0;
         non0_ff <= '0;
         non1_ff <= '0;
         ictr_ff <= '0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_KEY_0_7:    key0_ff <= csr_wdata;
            CSR_KEY_8_15:   key1_ff <= csr_wdata;
            CSR_KEY_16_23:  key2_ff <= csr_wdata;
            CSR_KEY_24_31:  key3_ff <= csr_wdata;
            CSR_NONCE_0_7:  non0_ff <= csr_wdata;
            CSR_NONCE_8_11: non1_ff <= csr_wdata[31:0];
            CSR_INIT_CTR:   ictr_ff <= csr_wdata[31:0];
            default: ;
         endcase
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

/* test/tb_chacha20_stream_xor_unit.sv */
// Self-checking testbench of the ChaCha20 stream XOR unit, with its own keystream model.
module tb_chacha20_stream_xor_unit;
   timeunit 1ns;
   timeprecision 1ps;

   import ccx_pkg::*;

   localparam int ROUNDS       = CCX_ROUND_COUNT;
   localparam int RANDOM_ITEMS = 450;
   localparam int DRAIN_CYCLES = 120;
   localparam int HOLD_CYCLES  = 400;
   localparam int CYCLE_LIMIT  = 1000000;
   localparam logic [CCX_CSR_INDEX_W-1:0] CSR_SPARE = 3'd7;
   localparam logic [CCX_CSR_DATA_W-1:0]  ALL_ONES  = '1;

   typedef struct packed {
      logic       last;
      logic [7:0] data;
   } stream_byte_type;

   typedef enum {CFG_ZERO, CFG_ONES, CFG_WRAP, CFG_RANDOM} cfg_mode_type;

   logic                       clock;
   logic                       reset      = 1'b1;
   logic                       req_tvalid = 1'b0;
   logic                       req_tready;
   logic [7:0]                 req_tdata  = '0;   // [7:0] data_byte
   logic                       req_tlast  = 1'b0; // last_byte
   logic                       rsp_tvalid;
   logic                       rsp_tready = 1'b0;
   logic [7:0]                 rsp_tdata;         // [7:0] out_byte
   logic                       rsp_tlast;         // out_last
   logic                       csr_we     = 1'b0;
   logic [CCX_CSR_INDEX_W-1:0] csr_index  = '0;
   logic [CCX_CSR_DATA_W-1:0]  csr_wdata  = '0;

   // Keystream model: register copies and per-message state.
   logic [63:0] key_reg [4] = '{default: '0};
   logic [63:0] nonce_lo_reg  = '0;
   logic [31:0] nonce_hi_reg  = '0;
   logic [31:0] init_ctr_reg  = '0;
   logic [31:0] mix [16];
   logic [7:0]  keystream [64];
   logic [31:0] blocks_in_msg = '0;
   int          keystream_pos = 64;

   stream_byte_type plain_pending[$];
   stream_byte_type cipher_expect[$];

   int   error_count    = 0;
   int   accepted_count = 0;
   int   checked_count  = 0;
   int   issued_count   = 0;
   int   message_count  = 0;
   int   phase_count    = 0;
   int   cycle_count    = 0;
   int   open_len       = 0;
   int   req_gap        = 0;
   int   rsp_stall      = 0;
   bit   burst_mode     = 1'b0;
   bit   hold_trigger   = 1'b0;
   logic rx_hold        = 1'b0;

   chacha20_stream_xor_unit #(
      .ROUND_COUNT(ROUNDS)
   ) u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   function automatic logic [31:0] rot32(input logic [31:0] v, input int n);
      return (v << n) | (v >> (32 - n));
   endfunction

   function automatic void quarter_mix(input int a, input int b, input int c, input int d);
      mix[a] = mix[a] + mix[b]; mix[d] = rot32(mix[d] ^ mix[a], 16);
      mix[c] = mix[c] + mix[d]; mix[b] = rot32(mix[b] ^ mix[c], 12);
      mix[a] = mix[a] + mix[b]; mix[d] = rot32(mix[d] ^ mix[a], 8);
      mix[c] = mix[c] + mix[d]; mix[b] = rot32(mix[b] ^ mix[c], 7);
   endfunction

   function automatic void refill_keystream();
      logic [31:0] seed [16];
      logic [31:0] sum;
      for (int i = 0; i < 4; i++) begin
         seed[i]         = CCX_SIGMA[32*i +: 32];
         seed[4 + 2*i]   = key_reg[i][31:0];
         seed[5 + 2*i]   = key_reg[i][63:32];
      end
      seed[12] = init_ctr_reg + blocks_in_msg;
      seed[13] = nonce_lo_reg[31:0];
      seed[14] = nonce_lo_reg[63:32];
      seed[15] = nonce_hi_reg;
      for (int i = 0; i < 16; i++) mix[i] = seed[i];
      // An odd round count still runs a full column/diagonal pair at the end.
      for (int r = ROUNDS; r > 0; r -= 2) begin
         quarter_mix(0, 4, 8, 12);
         quarter_mix(1, 5, 9, 13);
         quarter_mix(2, 6, 10, 14);
         quarter_mix(3, 7, 11, 15);
         quarter_mix(0, 5, 10, 15);
         quarter_mix(1, 6, 11, 12);
         quarter_mix(2, 7, 8, 13);
         quarter_mix(3, 4, 9, 14);
      end
      for (int i = 0; i < 16; i++) begin
         sum = mix[i] + seed[i];
         for (int k = 0; k < 4; k++) keystream[4*i + k] = sum[8*k +: 8];
      end
   endfunction

   function automatic void predict_cipher_byte(input logic [7:0] d, input logic l);
      stream_byte_type res;
      if (keystream_pos >= 64) begin
         refill_keystream();
         blocks_in_msg = blocks_in_msg + 1;
         keystream_pos = 0;
      end
      res.data = d ^ keystream[keystream_pos[5:0]];
      res.last = l;
      cipher_expect.push_back(res);
      keystream_pos++;
      if (l) begin
         blocks_in_msg = '0;
         keystream_pos = 64;
      end
   endfunction

   function automatic int pick_idle();
      int r;
      r = $urandom_range(0, 99);
      if (r < 65) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 98) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   task automatic report_mismatch(input string msg);
      error_count++;
      if (error_count <= 40) $display("MISMATCH at %0t ns: %s", $time, msg);
   endtask

   // Request driver: also runs the keystream model on every accepted request.
   always @(posedge clock) begin
      stream_byte_type nxt;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            predict_cipher_byte(req_tdata, req_tlast);
            accepted_count++;
         end
         if (!req_tvalid || req_tready) begin
            if (req_gap > 0) begin
               req_gap--;
               req_tvalid <= 1'b0;
            end else if (plain_pending.size() != 0) begin
               nxt = plain_pending.pop_front();
               req_tvalid <= 1'b1;
               req_tdata  <= nxt.data;
               req_tlast  <= nxt.last;
               req_gap = burst_mode ? 0 : pick_idle();
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Response monitor and output back-pressure.
   always @(posedge clock) begin
      stream_byte_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (cipher_expect.size() == 0) begin
               report_mismatch($sformatf("unexpected response %02h last %0b",
                                         rsp_tdata, rsp_tlast));
            end else begin
               want = cipher_expect.pop_front();
               if (rsp_tdata !== want.data)
                  report_mismatch($sformatf("response %0d: out_byte %02h, expected %02h",
                                            checked_count, rsp_tdata, want.data));
               if (rsp_tlast !== want.last)
                  report_mismatch($sformatf("response %0d: out_last %0b, expected %0b",
                                            checked_count, rsp_tlast, want.last));
            end
            checked_count++;
         end
         if (rx_hold) begin
            rsp_tready <= 1'b0;
         end else if (rsp_stall > 0) begin
            rsp_stall--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
            if (!burst_mode) rsp_stall = pick_idle();
         end
      end
   end

   // Long receiver hold-off so that the unit backs up into its input.
   initial begin
      wait (hold_trigger);
      @(posedge clock);
      rx_hold <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      rx_hold <= 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles, %0d responses still due.",
                  cycle_count, cipher_expect.size());
         $display("tb_chacha20_stream_xor_unit: done, errors");
         $finish;
      end
   end

   task automatic write_csr(input logic [CCX_CSR_INDEX_W-1:0] idx,
                            input logic [CCX_CSR_DATA_W-1:0] value);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      case (idx)
         CSR_KEY_0_7:    key_reg[0]   = value;
         CSR_KEY_8_15:   key_reg[1]   = value;
         CSR_KEY_16_23:  key_reg[2]   = value;
         CSR_KEY_24_31:  key_reg[3]   = value;
         CSR_NONCE_0_7:  nonce_lo_reg = value;
         CSR_NONCE_8_11: nonce_hi_reg = value[31:0];
         CSR_INIT_CTR:   init_ctr_reg = value[31:0];
         default: ;
      endcase
   endtask

   task automatic end_csr_writes();
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic push_byte(input logic [7:0] d, input logic l);
      stream_byte_type item;
      item.data = d;
      item.last = l;
      plain_pending.push_back(item);
      issued_count++;
      if (l) begin
         open_len = 0;
         message_count++;
      end else begin
         open_len++;
      end
   endtask

   task automatic push_message(input int len, input bit close);
      logic [7:0] d;
      for (int i = 0; i < len; i++) begin
         case ($urandom_range(0, 7))
            0:       d = 8'h00;
            1:       d = 8'hff;
            default: d = 8'($urandom);
         endcase
         push_byte(d, close && i == len - 1);
      end
   endtask

   task automatic wait_for_idle();
      @(negedge clock);
      while (plain_pending.size() != 0 || req_tvalid || cipher_expect.size() != 0)
         @(negedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      phase_count++;
   endtask

   task automatic load_random_config(output bit wrap_case);
      cfg_mode_type mode;
      logic [CCX_CSR_DATA_W-1:0] v;
      case ($urandom_range(0, 9))
         0:       mode = CFG_ZERO;
         1:       mode = CFG_ONES;
         2:       mode = CFG_WRAP;
         default: mode = CFG_RANDOM;
      endcase
      wrap_case = (mode == CFG_WRAP);
      for (int i = 0; i < 7; i++) begin
         if (mode != CFG_RANDOM || $urandom_range(0, 1) == 1) begin
            case (mode)
               CFG_ZERO: v = '0;
               CFG_ONES: v = ALL_ONES;
               default:  v = {$urandom, $urandom};
            endcase
            if (mode == CFG_WRAP && CCX_CSR_INDEX_W'(i) == CSR_INIT_CTR)
               v = {$urandom, 32'hffff_ffff};
            write_csr(CCX_CSR_INDEX_W'(i), v);
         end
      end
      if ($urandom_range(0, 4) == 0) write_csr(CSR_SPARE, {$urandom, $urandom});
      end_csr_writes();
   endtask

   initial begin : stimulus
      bit wrap_case;
      int stop_at;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Reset settings: all-zero key, nonce and counter.
      @(negedge clock);
      push_byte(8'h00, 1'b0);
      push_byte(8'hff, 1'b0);
      push_byte(8'ha5, 1'b0);
      push_byte(8'h5a, 1'b0);
      push_byte(8'h00, 1'b1);
      push_byte(8'hff, 1'b1);
      push_byte(8'h3c, 1'b0);
      push_byte(8'hc3, 1'b0);
      push_byte(8'h81, 1'b0);
      wait_for_idle();

      // All registers to ones while a message is open; the spare index must be ignored.
      // The open message keeps the bytes already in its buffer.
      for (int i = 0; i < 7; i++) write_csr(CCX_CSR_INDEX_W'(i), ALL_ONES);
      write_csr(CSR_SPARE, {$urandom, $urandom});
      end_csr_writes();
      @(negedge clock);
      push_byte(8'h00, 1'b0);
      push_byte(8'hff, 1'b0);
      push_byte(8'h0f, 1'b0);
      push_byte(8'hf0, 1'b1);
      push_byte(8'h7e, 1'b1);
      wait_for_idle();

      // Counter wraps inside a long message while the receiver holds off.
      write_csr(CSR_KEY_8_15, {$urandom, $urandom});
      write_csr(CSR_INIT_CTR, 64'h0000_0000_ffff_ffff);
      end_csr_writes();
      burst_mode = 1'b1;
      @(negedge clock);
      push_message(130, 1'b1);
      hold_trigger = 1'b1;
      wait_for_idle();

      stop_at = issued_count + RANDOM_ITEMS;
      while (issued_count < stop_at) begin
         load_random_config(wrap_case);
         burst_mode = ($urandom_range(0, 3) == 0);
         @(negedge clock);
         if (wrap_case) push_message($urandom_range(65, 130), 1'b1);
         for (int m = $urandom_range(1, 4); m > 0; m--) begin
            if ($urandom_range(0, 5) == 0) push_message($urandom_range(60, 140), 1'b1);
            else push_message($urandom_range(1, 20), 1'b1);
         end
         // Leave a message open across the next register writes, never on a block edge.
         if ($urandom_range(0, 3) == 0) begin
            push_message($urandom_range(1, 90), 1'b0);
            if (open_len % 64 == 0) push_message(1, 1'b0);
         end
         wait_for_idle();
      end

      $display("Run: %0d requests in %0d messages over %0d phases, %0d responses checked.",
               accepted_count, message_count, phase_count, checked_count);
      $display("Run: zero and all-ones settings, counter wrap, writes inside open messages,");
      $display("     %0d-cycle hold-off.", HOLD_CYCLES);
      if (error_count == 0 && cipher_expect.size() == 0) begin
         $display("tb_chacha20_stream_xor_unit: done, clean");
      end else begin
         $display("tb_chacha20_stream_xor_unit: done, errors");
      end
      $finish;
   end

endmodule

/* files.f */
sv/ccx_pkg.sv
sv/ccx_lane_alu.sv
sv/ccx_core.sv
sv/chacha20_stream_xor_unit.sv
test/tb_chacha20_stream_xor_unit.sv
